>>> rtl/utf8_dec_pkg.sv
// ----------------------------------------------------------------------------
// utf8_dec_pkg
// shared types, constants and lead byte helpers for the utf8 stream decoder
// ----------------------------------------------------------------------------
package utf8_dec_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned CpW     = 36;
	localparam int unsigned LenW    = 3;
	localparam int unsigned PayW    = 6;
	localparam int unsigned OutPadW = ((CpW + LenW + 7) / 8) * 8;

	localparam logic [1:0]      LeadTag   = 2'b11;
	localparam logic [LenW-1:0] LenSingle = 3'd1;
	localparam logic [LenW-1:0] FollowMax = 3'd6;

	typedef struct packed {
		logic            valid;
		logic [CpW-1:0]  code_point;
		logic [LenW-1:0] seq_length;
	} result_t;

	// number of following bytes set by a lead byte, capped at six
	function automatic logic [LenW-1:0] follow_count(input logic [ByteW-1:0] b);
		logic [LenW-1:0] n;
		if (!b[5]) begin
			n = 3'd1;
		end else if (!b[4]) begin
			n = 3'd2;
		end else if (!b[3]) begin
			n = 3'd3;
		end else if (!b[2]) begin
			n = 3'd4;
		end else if (!b[1]) begin
			n = 3'd5;
		end else begin
			n = FollowMax;
		end
		return n;
	endfunction

	// payload bits that the lead byte keeps
	function automatic logic [PayW-1:0] lead_bits(input logic [ByteW-1:0] b,
		input logic [LenW-1:0] n);
		logic [PayW-1:0] mask;
		mask = 6'h3f >> n;
		return b[PayW-1:0] & mask;
	endfunction

endpackage

>>> rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// rebuilds code points of up to 36 bits from a utf-8 byte stream
// ----------------------------------------------------------------------------
//  channel   dir  tdata bits (low first)
//  s_axis    in   in_byte[7:0]
//  m_axis    out  code_point[35:0], seq_length[38:36], zero pad[39]
//
//  one byte accepted per cycle unless m_axis stalls; the byte that completes a
//  result passes the input register, then the result register
//  lead and middle bytes give no result, only update sequence state
//  a stall on m_axis holds the result register and then the input register
//  reset clears the sequence state and both valid flags
// ----------------------------------------------------------------------------
module utf8_stream_decoder
	import utf8_dec_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [ByteW-1:0]   s_axis_tdata,   // in_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OutPadW-1:0] m_axis_tdata    // code_point, seq_length, pad
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             out_valid_q;
	logic [CpW-1:0]   cp_q;
	logic [LenW-1:0]  len_q;
	logic             adv;
	logic             step_en;
	result_t          res;

	assign adv           = !out_valid_q || m_axis_tready;
	assign step_en       = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	utf8_dec_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.in_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step_en && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res.valid) begin
			cp_q  <= res.code_point;
			len_q <= res.seq_length;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OutPadW-CpW-LenW){1'b0}}, len_q, cp_q};

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a byte during stall");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> len_q != '0)
		else $error("result with zero sequence length");

endmodule

>>> rtl/utf8_dec_core.sv
// ----------------------------------------------------------------------------
// utf8_dec_core
// sequence state and per-byte decode step
// ----------------------------------------------------------------------------
module utf8_dec_core
	import utf8_dec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [ByteW-1:0] in_byte,
	output result_t          res
);

	logic [LenW-1:0] remaining_q;
	logic [LenW-1:0] taken_q;
	logic [CpW-1:0]  acc_q;

	logic [LenW-1:0] follow;
	logic [CpW-1:0]  acc_shift;
	logic [LenW-1:0] taken_inc;
	logic            idle;
	logic            is_lead;

	assign idle      = (remaining_q == '0);
	assign is_lead   = (in_byte[7:6] == LeadTag);
	assign follow    = follow_count(in_byte);
	assign acc_shift = {acc_q[CpW-PayW-1:0], in_byte[PayW-1:0]};
	assign taken_inc = taken_q + 3'd1;

	always_comb begin
		res.valid      = 1'b0;
		res.code_point = acc_shift;
		res.seq_length = taken_inc;
		if (idle) begin
			res.valid      = !is_lead;
			res.code_point = {{(CpW-ByteW){1'b0}}, in_byte};
			res.seq_length = LenSingle;
		end else begin
			res.valid = (remaining_q == 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			taken_q     <= '0;
			acc_q       <= '0;
		end else if (step_en) begin
			if (idle) begin
				if (is_lead) begin
					remaining_q <= follow;
					taken_q     <= 3'd1;
					acc_q       <= {{(CpW-PayW){1'b0}}, lead_bits(in_byte, follow)};
				end
			end else if (remaining_q == 3'd1) begin
				remaining_q <= '0;
				taken_q     <= '0;
				acc_q       <= '0;
			end else begin
				remaining_q <= remaining_q - 3'd1;
				taken_q     <= taken_inc;
				acc_q       <= acc_shift;
			end
		end
	end

	a_lead_opens: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && idle && is_lead |=> remaining_q != '0)
		else $error("lead byte did not open a sequence");

	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.valid |=> remaining_q == '0 && taken_q == '0)
		else $error("sequence state not cleared after emit");

	a_total_kept: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && remaining_q > 3'd1 |=>
		({1'b0, taken_q} + {1'b0, remaining_q}) ==
		$past({1'b0, taken_q} + {1'b0, remaining_q}))
		else $error("sequence length drifted mid-sequence");

endmodule
